[rtl/servo_pulse_slew_limiter_unit_macros.svh]
// assertion macros shared by the rtl files
`ifndef SERVO_PULSE_SLEW_LIMITER_UNIT_MACROS_SVH
`define SERVO_PULSE_SLEW_LIMITER_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SPSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/spsl_pkg.sv]
package spsl_pkg;

  // channel count and derived index width
  localparam int CHANNELS = 6;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] CH_LAST = IDX_W'(CHANNELS - 1);

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE         = 3'd0,
    REG_ANGLE_LOW         = 3'd1,
    REG_ANGLE_HIGH        = 3'd2,
    REG_PULSE_BASE        = 3'd3,
    REG_PULSES_PER_DEGREE = 3'd4,
    REG_DEGREES_PER_PULSE = 3'd5
  } spsl_reg_t;

  // register reset values
  localparam logic [15:0] RST_STEP_SIZE = 16'd10;
  localparam logic signed [12:0] RST_ANGLE_LOW = 13'sd0;
  localparam logic signed [12:0] RST_ANGLE_HIGH = 13'sd2880;
  localparam logic [15:0] RST_PULSE_BASE = 16'd500;
  localparam logic [15:0] RST_PULSES_PER_DEGREE = 16'd2844;
  localparam logic [15:0] RST_DEGREES_PER_PULSE = 16'd5898;

  // saturation limits of the reported angle
  localparam logic signed [22:0] ANGLE_SAT_MAX = 23'sd4095;
  localparam logic signed [22:0] ANGLE_SAT_MIN = -23'sd4096;

  // input mode codes
  localparam logic MODE_SET_TARGET = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_MUL,
    S_SET_WR,
    S_UPD,
    S_ANG_MUL,
    S_EMIT
  } spsl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic             load_in;
    logic             set_mul;
    logic             set_wr;
    logic             upd;
    logic             ang_mul;
    logic             emit;
    logic [IDX_W-1:0] idx;
  } spsl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
  } spsl_sts_t;

  // per-channel pulse after reset
  function automatic logic [15:0] reset_pulse(int ch);
    logic [15:0] v;
    case (ch)
      0: v = 16'd1055;
      1: v = 16'd2500;
      2: v = 16'd778;
      3: v = 16'd2444;
      4: v = 16'd2500;
      5: v = 16'd722;
      default: v = 16'd500;
    endcase
    return v;
  endfunction

endpackage

[rtl/spsl_in_if.sv]
interface spsl_in_if;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [2:0]        channel;
  logic signed [12:0] angle;

  modport source (output valid, output mode, output channel, output angle, input ready);
  modport sink (input valid, input mode, input channel, input angle, output ready);
endinterface

[rtl/spsl_out_if.sv]
interface spsl_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_channel;
  logic [15:0]        pulse_width;
  logic signed [12:0] reached_angle;
  logic               all_settled;
  logic               last;

  modport source (output valid, output out_channel, output pulse_width,
                  output reached_angle, output all_settled, output last, input ready);
  modport sink (input valid, input out_channel, input pulse_width,
                input reached_angle, input all_settled, input last, output ready);
endinterface

[rtl/spsl_cfg_if.sv]
interface spsl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [spsl_pkg::CFG_IDX_W-1:0]   index;
  logic [spsl_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/spsl_ctrl.sv]
module spsl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  input  spsl_pkg::spsl_sts_t sts,
  output spsl_pkg::spsl_cmd_t cmd
);

  spsl_pkg::spsl_state_t state, state_next;
  logic [spsl_pkg::IDX_W-1:0] idx, idx_next;

  // state and channel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spsl_pkg::S_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    idx_next = idx;
    unique case (state)
      spsl_pkg::S_IDLE: begin
        idx_next = '0;
        if (in_valid) begin
          state_next = (in_mode == spsl_pkg::MODE_TICK) ? spsl_pkg::S_UPD
                                                        : spsl_pkg::S_SET_MUL;
        end
      end
      spsl_pkg::S_SET_MUL: state_next = spsl_pkg::S_SET_WR;
      spsl_pkg::S_SET_WR:  state_next = spsl_pkg::S_IDLE;
      spsl_pkg::S_UPD: begin
        if (idx == spsl_pkg::CH_LAST) begin
          state_next = spsl_pkg::S_ANG_MUL;
          idx_next = '0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      spsl_pkg::S_ANG_MUL: state_next = spsl_pkg::S_EMIT;
      spsl_pkg::S_EMIT: begin
        if (sts.out_free) begin
          if (idx == spsl_pkg::CH_LAST) begin
            state_next = spsl_pkg::S_IDLE;
            idx_next = '0;
          end else begin
            state_next = spsl_pkg::S_ANG_MUL;
            idx_next = idx + 1'b1;
          end
        end
      end
      default: state_next = spsl_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state == spsl_pkg::S_IDLE);
    cmd.load_in = (state == spsl_pkg::S_IDLE) && in_valid;
    cmd.set_mul = (state == spsl_pkg::S_SET_MUL);
    cmd.set_wr = (state == spsl_pkg::S_SET_WR);
    cmd.upd = (state == spsl_pkg::S_UPD);
    cmd.ang_mul = (state == spsl_pkg::S_ANG_MUL);
    cmd.emit = (state == spsl_pkg::S_EMIT) && sts.out_free;
    cmd.idx = idx;
  end

`include "servo_pulse_slew_limiter_unit_macros.svh"

  `SPSL_ASSERT_NEXT(a_tick_starts_at_ch0, in_valid && in_ready && (in_mode == spsl_pkg::MODE_TICK), (state == spsl_pkg::S_UPD) && (idx == '0), "tick did not start update at channel zero")
  `SPSL_ASSERT_NEXT(a_last_emit_idles, cmd.emit && (idx == spsl_pkg::CH_LAST), state == spsl_pkg::S_IDLE, "sequencer did not return to idle after last result")
  `SPSL_ASSERT_NOW(a_idx_in_range, 1'b1, idx <= spsl_pkg::CH_LAST, "channel counter out of range")
  `SPSL_ASSERT_NEXT(a_set_no_update, cmd.set_mul, cmd.set_wr, "set-target write did not follow multiply")

endmodule

[rtl/spsl_dpath.sv]
module spsl_dpath (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          in_channel,
  input  logic signed [12:0]  in_angle,
  input  spsl_pkg::spsl_cmd_t cmd,
  output spsl_pkg::spsl_sts_t sts,
  spsl_cfg_if.sink            cfg,
  spsl_out_if.source          result
);

  // configuration registers
  logic [15:0]        step_size;
  logic signed [12:0] angle_low;
  logic signed [12:0] angle_high;
  logic [15:0]        pulse_base;
  logic [15:0]        pulses_per_degree;
  logic [15:0]        degrees_per_pulse;

  // channel state
  logic [15:0] current_pulse [spsl_pkg::CHANNELS];
  logic [15:0] target_pulse [spsl_pkg::CHANNELS];
  logic        settled;

  // latched input and products
  logic [2:0]         ch_q;
  logic signed [12:0] ang_q;
  logic [28:0]        prod_set;
  logic signed [33:0] prod_ang;

  // output register
  logic               out_valid;
  logic [2:0]         out_channel;
  logic [15:0]        pulse_width;
  logic signed [12:0] reached_angle;
  logic               all_settled;
  logic               last;

  // combinational intermediates
  logic signed [12:0] ang_hi_clamp;
  logic signed [12:0] ang_clamp;
  logic signed [13:0] ang_off_s;
  logic [12:0]        ang_off;
  logic [17:0]        set_sum;
  logic [15:0]        set_pulse;
  logic [15:0]        cur;
  logic [15:0]        tgt;
  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic               stepped;
  logic [15:0]        cur_new;
  logic signed [16:0] pulse_off;
  logic signed [16:0] dpp_s;
  logic signed [22:0] ang_sum;
  logic signed [12:0] ang_sat;

  assign cfg.ready = 1'b1;
  assign sts.out_free = !out_valid || result.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= spsl_pkg::RST_STEP_SIZE;
      angle_low <= spsl_pkg::RST_ANGLE_LOW;
      angle_high <= spsl_pkg::RST_ANGLE_HIGH;
      pulse_base <= spsl_pkg::RST_PULSE_BASE;
      pulses_per_degree <= spsl_pkg::RST_PULSES_PER_DEGREE;
      degrees_per_pulse <= spsl_pkg::RST_DEGREES_PER_PULSE;
    end else if (cfg.valid) begin
      unique case (spsl_pkg::spsl_reg_t'(cfg.index))
        spsl_pkg::REG_STEP_SIZE:         step_size <= cfg.data;
        spsl_pkg::REG_ANGLE_LOW:         angle_low <= $signed(cfg.data[12:0]);
        spsl_pkg::REG_ANGLE_HIGH:        angle_high <= $signed(cfg.data[12:0]);
        spsl_pkg::REG_PULSE_BASE:        pulse_base <= cfg.data;
        spsl_pkg::REG_PULSES_PER_DEGREE: pulses_per_degree <= cfg.data;
        spsl_pkg::REG_DEGREES_PER_PULSE: degrees_per_pulse <= cfg.data;
        default: ;
      endcase
    end
  end

  // clamp angle to range, crossed limits give the low limit
  always_comb begin
    ang_hi_clamp = (ang_q > angle_high) ? angle_high : ang_q;
    ang_clamp = (ang_hi_clamp < angle_low) ? angle_low : ang_hi_clamp;
    ang_off_s = 14'(ang_clamp) - 14'(angle_low);
    ang_off = ang_off_s[12:0];
  end

  // base plus scaled offset, saturated to 16 bits
  always_comb begin
    set_sum = 18'(pulse_base) + 18'(prod_set[28:12]);
    set_pulse = (|set_sum[17:16]) ? 16'hFFFF : set_sum[15:0];
  end

  // one channel of the slew step
  always_comb begin
    cur = current_pulse[cmd.idx];
    tgt = target_pulse[cmd.idx];
    diff = $signed({1'b0, tgt}) - $signed({1'b0, cur});
    mag = diff[16] ? 17'(-diff) : 17'(diff);
    stepped = mag > {1'b0, step_size};
    if (!stepped) begin
      cur_new = tgt;
    end else if (diff[16]) begin
      cur_new = cur - step_size;
    end else begin
      cur_new = cur + step_size;
    end
  end

  // pulse back to angle: floor shift, offset, saturate
  always_comb begin
    pulse_off = $signed({1'b0, cur}) - $signed({1'b0, pulse_base});
    dpp_s = $signed({1'b0, degrees_per_pulse});
    ang_sum = 23'($signed(prod_ang[33:12])) + 23'(angle_low);
    if (ang_sum > spsl_pkg::ANGLE_SAT_MAX) begin
      ang_sat = 13'sd4095;
    end else if (ang_sum < spsl_pkg::ANGLE_SAT_MIN) begin
      ang_sat = -13'sd4096;
    end else begin
      ang_sat = ang_sum[12:0];
    end
  end

  // input latch and multipliers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_q <= in_channel;
      ang_q <= in_angle;
    end
    if (cmd.set_mul) begin
      prod_set <= ang_off * pulses_per_degree;
    end
    if (cmd.ang_mul) begin
      prod_ang <= pulse_off * dpp_s;
    end
  end

  // channel pulse state and settled flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < spsl_pkg::CHANNELS; i++) begin
        current_pulse[i] <= spsl_pkg::reset_pulse(i);
        target_pulse[i] <= spsl_pkg::reset_pulse(i);
      end
      settled <= 1'b1;
    end else begin
      if (cmd.load_in) begin
        settled <= 1'b1;
      end else if (cmd.upd) begin
        settled <= settled && !stepped;
      end
      if (cmd.upd) begin
        current_pulse[cmd.idx] <= cur_new;
      end
      if (cmd.set_wr && (5'(ch_q) < 5'(spsl_pkg::CHANNELS))) begin
        target_pulse[spsl_pkg::IDX_W'(ch_q)] <= set_pulse;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_channel <= 3'(cmd.idx);
      pulse_width <= cur;
      reached_angle <= ang_sat;
      all_settled <= settled;
      last <= (cmd.idx == spsl_pkg::CH_LAST);
    end
  end

  assign result.valid = out_valid;
  assign result.out_channel = out_channel;
  assign result.pulse_width = pulse_width;
  assign result.reached_angle = reached_angle;
  assign result.all_settled = all_settled;
  assign result.last = last;

`include "servo_pulse_slew_limiter_unit_macros.svh"

  `SPSL_ASSERT_NOW(a_emit_when_free, cmd.emit, !out_valid || result.ready, "result loaded over an untaken beat")
  `SPSL_ASSERT_NEXT(a_settled_held, !cmd.upd && !cmd.load_in, $stable(settled), "settled flag changed outside update")
  `SPSL_ASSERT_NOW(a_one_mul_at_a_time, cmd.set_mul || cmd.ang_mul, !(cmd.set_mul && cmd.ang_mul), "both multipliers loaded together")

endmodule

[rtl/servo_pulse_slew_limiter_unit.sv]
// channel | dir | beat contents
// item    | in  | mode, channel, angle
// result  | out | out_channel, pulse_width, reached_angle, all_settled, last
// cfg     | in  | index, data (register write, always ready)
//
// a set-target item is accepted, multiplied, then written as the channel target
// a tick is accepted, then updates one channel per cycle, then per channel runs a multiply
// step and an output load step, the load waiting while the result is stalled
// the angle multiplier and the single output register set the tick length
// reset (rst, synchronous) restores registers, channel pulses and targets
// the last result may wait in the output register while the next item is accepted
module servo_pulse_slew_limiter_unit (
  input  logic       clk,
  input  logic       rst,
  spsl_in_if.sink    item,
  spsl_out_if.source result,
  spsl_cfg_if.sink   cfg
);

  spsl_pkg::spsl_cmd_t cmd;
  spsl_pkg::spsl_sts_t sts;

  // sequencer
  spsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_mode  (item.mode),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // registers, channel state and arithmetic
  spsl_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .in_channel (item.channel),
    .in_angle   (item.angle),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg),
    .result     (result)
  );

endmodule

[tb/tb_servo_pulse_slew_limiter_unit.sv]
`timescale 1ns / 100ps

module tb_servo_pulse_slew_limiter_unit;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 105;

  // spare register indexes, writes to them must change nothing
  localparam logic [spsl_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [spsl_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic               mode;
    logic [2:0]         channel;
    logic signed [12:0] angle;
  } servo_cmd_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic [15:0]        pulse_width;
    logic signed [12:0] reached_angle;
    logic               all_settled;
    logic               last;
  } pulse_report_t;

  logic clk;
  logic rst;

  spsl_in_if  item_bus ();
  spsl_out_if res_bus ();
  spsl_cfg_if cfg_bus ();

  servo_pulse_slew_limiter_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (res_bus),
    .cfg    (cfg_bus)
  );

  // shadow copy of the servo state and registers
  logic [15:0]        step_q;
  logic signed [12:0] angle_low_q;
  logic signed [12:0] angle_high_q;
  logic [15:0]        pulse_base_q;
  logic [15:0]        ppd_q;
  logic [15:0]        dpp_q;
  logic [15:0]        current_pulse_q [spsl_pkg::CHANNELS];
  logic [15:0]        target_pulse_q [spsl_pkg::CHANNELS];

  servo_cmd_t    item_backlog [$];
  pulse_report_t pulse_reports [$];
  servo_cmd_t    in_flight;

  int beats_queued = 0;
  int beats_accepted = 0;
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_arm;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic home_model();
    logic [15:0] home [6];
    home = '{16'd1055, 16'd2500, 16'd778, 16'd2444, 16'd2500, 16'd722};
    step_q = 16'd10;
    angle_low_q = 13'sd0;
    angle_high_q = 13'sd2880;
    pulse_base_q = 16'd500;
    ppd_q = 16'd2844;
    dpp_q = 16'd5898;
    for (int i = 0; i < spsl_pkg::CHANNELS; i++) begin
      current_pulse_q[i] = (i < 6) ? home[i] : 16'd500;
      target_pulse_q[i] = current_pulse_q[i];
    end
  endtask

  // clamp, then scale by Q4.12 pulses per degree, saturating at 16 bits
  function automatic logic [15:0] angle_to_pulse_width(logic signed [12:0] ang);
    longint lo, hi, a, base, scale, p;
    lo = angle_low_q;
    hi = angle_high_q;
    a = ang;
    base = pulse_base_q;
    scale = ppd_q;
    if (a > hi) a = hi;
    if (a < lo) a = lo;
    p = base + (a - lo) * scale / 4096;
    if (p > 65535) p = 65535;
    return p[15:0];
  endfunction

  // floor of signed offset times Q4.12 scale plus low limit, saturated to 13 bits signed
  function automatic logic signed [12:0] pulse_width_to_angle(logic [15:0] pw);
    longint d, a, base, scale, pwl;
    pwl = pw;
    base = pulse_base_q;
    scale = dpp_q;
    d = pwl - base;
    a = ((d * scale) >>> 12) + longint'(angle_low_q);
    if (a > 4095) a = 4095;
    if (a < -4096) a = -4096;
    return a[12:0];
  endfunction

  // apply one accepted beat to the shadow state, queue the tick reports
  task automatic predict_item(servo_cmd_t cmd);
    pulse_report_t rep;
    logic all_done;
    int cur, tgt, diff, mag, step;
    if (cmd.mode == spsl_pkg::MODE_SET_TARGET) begin
      if (cmd.channel < spsl_pkg::CHANNELS)
        target_pulse_q[cmd.channel] = angle_to_pulse_width(cmd.angle);
    end else begin
      all_done = 1'b1;
      step = step_q;
      for (int i = 0; i < spsl_pkg::CHANNELS; i++) begin
        cur = current_pulse_q[i];
        tgt = target_pulse_q[i];
        diff = tgt - cur;
        mag = (diff < 0) ? -diff : diff;
        if (mag > step) begin
          cur = (diff >= 0) ? cur + step : cur - step;
          all_done = 1'b0;
        end else begin
          cur = tgt;
        end
        current_pulse_q[i] = cur[15:0];
      end
      for (int i = 0; i < spsl_pkg::CHANNELS; i++) begin
        rep.out_channel = i[2:0];
        rep.pulse_width = current_pulse_q[i];
        rep.reached_angle = pulse_width_to_angle(current_pulse_q[i]);
        rep.all_settled = all_done;
        rep.last = (i == spsl_pkg::CHANNELS - 1);
        pulse_reports.push_back(rep);
      end
    end
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        predict_item(in_flight);
        beats_accepted++;
      end
      if (!item_bus.valid || item_bus.ready) begin
        if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = item_backlog.pop_front();
          item_bus.valid <= 1'b1;
          item_bus.mode <= in_flight.mode;
          item_bus.channel <= in_flight.channel;
          item_bus.angle <= in_flight.angle;
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_report();
    pulse_report_t want;
    if (pulse_reports.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing expected, channel %0d",
                                res_bus.out_channel));
    end else begin
      want = pulse_reports.pop_front();
      if (res_bus.out_channel !== want.out_channel)
        report_mismatch($sformatf("out_channel %0d, expected %0d",
                                  res_bus.out_channel, want.out_channel));
      if (res_bus.pulse_width !== want.pulse_width)
        report_mismatch($sformatf("ch %0d pulse_width %0d, expected %0d", want.out_channel,
                                  res_bus.pulse_width, want.pulse_width));
      if (res_bus.reached_angle !== want.reached_angle)
        report_mismatch($sformatf("ch %0d reached_angle %0d, expected %0d", want.out_channel,
                                  res_bus.reached_angle, want.reached_angle));
      if (res_bus.all_settled !== want.all_settled)
        report_mismatch($sformatf("ch %0d all_settled %0b, expected %0b", want.out_channel,
                                  res_bus.all_settled, want.all_settled));
      if (res_bus.last !== want.last)
        report_mismatch($sformatf("ch %0d last %0b, expected %0b", want.out_channel,
                                  res_bus.last, want.last));
    end
  endtask

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready)
        check_report();
      res_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst)
      hold_left <= 0;
    else if (hold_arm)
      hold_left <= HOLD_CYCLES;
    else if (hold_left > 0)
      hold_left <= hold_left - 1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_item(logic mode, logic [2:0] ch, logic signed [12:0] ang);
    servo_cmd_t cmd;
    cmd.mode = mode;
    cmd.channel = ch;
    cmd.angle = ang;
    item_backlog.push_back(cmd);
    beats_queued++;
  endtask

  task automatic write_reg(logic [spsl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] word);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= word;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    case (idx)
      spsl_pkg::REG_STEP_SIZE:         step_q = word;
      spsl_pkg::REG_ANGLE_LOW:         angle_low_q = word[12:0];
      spsl_pkg::REG_ANGLE_HIGH:        angle_high_q = word[12:0];
      spsl_pkg::REG_PULSE_BASE:        pulse_base_q = word;
      spsl_pkg::REG_PULSES_PER_DEGREE: ppd_q = word;
      spsl_pkg::REG_DEGREES_PER_PULSE: dpp_q = word;
      default: ;
    endcase
  endtask

  // wait until every beat is in and every report is out, then let the block drain
  task automatic settle_block();
    while (item_backlog.size() != 0 || beats_accepted != beats_queued ||
           pulse_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_channel();
    if ($urandom_range(9) == 0)
      return 3'($urandom_range(spsl_pkg::CHANNELS, 7));
    return 3'($urandom_range(spsl_pkg::CHANNELS - 1));
  endfunction

  function automatic logic signed [12:0] pick_angle();
    case ($urandom_range(7))
      0: return 13'h1000;
      1: return 13'sd4095;
      2: return angle_low_q;
      3: return angle_high_q;
      default: return 13'($urandom);
    endcase
  endfunction

  // random register set, upper data bits of the angle limits are junk
  task automatic randomize_config();
    int lo, hi;
    logic [15:0] word;
    case ($urandom_range(4))
      0: word = 16'd0;
      1: word = 16'd1;
      2: word = 16'($urandom_range(2, 80));
      3: word = 16'($urandom);
      default: word = 16'hFFFF;
    endcase
    write_reg(spsl_pkg::REG_STEP_SIZE, word);
    lo = int'($urandom_range(1600)) - 800;
    hi = lo + int'($urandom_range(3200));
    if (hi > 4095) hi = 4095;
    if ($urandom_range(9) == 0) begin
      lo = int'($urandom_range(8191)) - 4096;
      hi = int'($urandom_range(8191)) - 4096;
    end
    word = 16'($urandom);
    word[12:0] = lo[12:0];
    write_reg(spsl_pkg::REG_ANGLE_LOW, word);
    word = 16'($urandom);
    word[12:0] = hi[12:0];
    write_reg(spsl_pkg::REG_ANGLE_HIGH, word);
    word = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(200, 1200));
    write_reg(spsl_pkg::REG_PULSE_BASE, word);
    word = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1000, 4000));
    write_reg(spsl_pkg::REG_PULSES_PER_DEGREE, word);
    word = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000, 9000));
    write_reg(spsl_pkg::REG_DEGREES_PER_PULSE, word);
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
  endtask

  // random config, then groups of up to six target updates, each followed by one to three ticks
  task automatic run_phase(int send_pct, int recv_pct, bit with_hold);
    int count;
    int n;
    count = 0;
    randomize_config();
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (with_hold) begin
      hold_arm = 1'b1;
      @(negedge clk);
      hold_arm = 1'b0;
      repeat (24) queue_item(spsl_pkg::MODE_TICK, 3'($urandom), 13'($urandom));
    end
    while (count < PHASE_ITEMS) begin
      n = $urandom_range(0, 6);
      repeat (n) queue_item(spsl_pkg::MODE_SET_TARGET, pick_channel(), pick_angle());
      count += n;
      n = $urandom_range(1, 3);
      repeat (n) queue_item(spsl_pkg::MODE_TICK, 3'($urandom), 13'($urandom));
      count += n;
    end
    settle_block();
  endtask

  initial begin
    rst = 1'b1;
    hold_arm = 1'b0;
    item_bus.valid = 1'b0;
    item_bus.mode = spsl_pkg::MODE_SET_TARGET;
    item_bus.channel = 3'd0;
    item_bus.angle = 13'sd0;
    res_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = spsl_pkg::REG_STEP_SIZE;
    cfg_bus.data = 16'd0;
    home_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values: settled tick, clamps at both ends, ignored channels, stepping
    @(negedge clk);
    queue_item(spsl_pkg::MODE_TICK, 3'd0, 13'sd0);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd0, 13'h1000);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd1, 13'sd4095);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd2, 13'sd0);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd5, 13'sd1440);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd6, 13'sd100);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd7, -13'sd1);
    queue_item(spsl_pkg::MODE_TICK, 3'd7, 13'h1FFF);
    queue_item(spsl_pkg::MODE_TICK, 3'd0, 13'sd0);
    settle_block();

    // zero step, crossed limits, pulse overflow, spare registers
    write_reg(spsl_pkg::REG_STEP_SIZE, 16'd0);
    write_reg(spsl_pkg::REG_ANGLE_LOW, 16'h0FFF);
    write_reg(spsl_pkg::REG_ANGLE_HIGH, 16'hF000);
    write_reg(spsl_pkg::REG_PULSE_BASE, 16'hFFFF);
    write_reg(spsl_pkg::REG_PULSES_PER_DEGREE, 16'hFFFF);
    write_reg(spsl_pkg::REG_DEGREES_PER_PULSE, 16'hFFFF);
    write_reg(REG_SPARE_6, 16'h0001);
    write_reg(REG_SPARE_7, 16'hFFFF);
    @(negedge clk);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd3, 13'sd4095);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd4, 13'h1000);
    queue_item(spsl_pkg::MODE_TICK, 3'd0, 13'sd0);
    settle_block();

    // full angle range, largest step, reported angle saturating at the top
    write_reg(spsl_pkg::REG_STEP_SIZE, 16'hFFFF);
    write_reg(spsl_pkg::REG_ANGLE_LOW, 16'h1000);
    write_reg(spsl_pkg::REG_ANGLE_HIGH, 16'h0FFF);
    write_reg(spsl_pkg::REG_PULSE_BASE, 16'd0);
    @(negedge clk);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd0, 13'sd4095);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd1, 13'h1000);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd2, 13'sd0);
    queue_item(spsl_pkg::MODE_TICK, 3'd0, 13'sd0);
    settle_block();

    // unit step with zero scales
    write_reg(spsl_pkg::REG_STEP_SIZE, 16'd1);
    write_reg(spsl_pkg::REG_PULSE_BASE, 16'd500);
    write_reg(spsl_pkg::REG_PULSES_PER_DEGREE, 16'd0);
    write_reg(spsl_pkg::REG_DEGREES_PER_PULSE, 16'd0);
    @(negedge clk);
    queue_item(spsl_pkg::MODE_SET_TARGET, 3'd5, 13'sd2000);
    queue_item(spsl_pkg::MODE_TICK, 3'd0, 13'sd0);
    queue_item(spsl_pkg::MODE_TICK, 3'd0, 13'sd0);
    settle_block();

    // random phases under each idling mix, one with a long receiver hold-off
    run_phase(0, 0, 1'b0);
    run_phase(47, 0, 1'b0);
    run_phase(0, 47, 1'b1);
    run_phase(38, 38, 1'b0);

    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/spsl_pkg.sv
rtl/spsl_in_if.sv
rtl/spsl_out_if.sv
rtl/spsl_cfg_if.sv
rtl/spsl_ctrl.sv
rtl/spsl_dpath.sv
rtl/servo_pulse_slew_limiter_unit.sv
tb/tb_servo_pulse_slew_limiter_unit.sv
